// ===== hw/rtl/ptest_pkg.sv =====
// Package for the 64-bit primality test core: types, constants, witness table.
// No dependencies.
package ptest_pkg;

  localparam int unsigned NumW  = 63;
  localparam int unsigned NBases = 7;
  localparam int unsigned BaseIdxW = 3;
  localparam int unsigned BitCntW = 6;

  typedef logic [NumW-1:0] num_t;

  typedef enum logic [3:0] {
    StIdle,
    StMod3,
    StBaseRed,
    StBaseChk,
    StSplit,
    StMulStart,
    StMulRun,
    StMulDone,
    StVerdictA,
    StSquareChk,
    StDone
  } state_e;

  typedef enum logic [1:0] {
    OpVB,
    OpBB,
    OpVV
  } mulop_e;

  function automatic num_t witness_base(input logic [BaseIdxW-1:0] idx);
    num_t b;
    b = '0;
    unique case (idx)
      3'd0:    b = num_t'(64'd2);
      3'd1:    b = num_t'(64'd325);
      3'd2:    b = num_t'(64'd9375);
      3'd3:    b = num_t'(64'd28178);
      3'd4:    b = num_t'(64'd450775);
      3'd5:    b = num_t'(64'd9780504);
      3'd6:    b = num_t'(64'd1795265022);
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== hw/rtl/primality_test_64bit_core.sv =====
// Top level of the 64-bit primality test (deterministic Miller-Rabin).
// Depends on ptest_pkg.
//
// channel | signals                              | dir
// in      | number_i, number_valid_i/ready_o      | request in
// out     | is_prime_o, is_prime_valid_o/ready_i  | request out
//
// One shared shift-and-add modular multiplier (63 steps, one bit a cycle)
// does every modular product under the sequencer below. n mod 15 is folded
// from nibble sums, 16 bits a cycle, top group first; mod 3 and mod 5 follow
// from it. Base mod n uses a restoring remainder pass over the base bits.
// For a large prime the run time is set by the multiplier loop.
// Reset clears the sequencer; the core accepts a request only when idle and
// the output register is empty, and holds the result until it is taken.
module primality_test_64bit_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [62:0]            number_i,
  input  logic                   number_valid_i,
  output logic                   number_ready_o,
  output logic                   is_prime_o,
  output logic                   is_prime_valid_o,
  input  logic                   is_prime_ready_i
);
  import ptest_pkg::*;

  state_e state_q, state_d;
  num_t n_q, n_d, d_q, d_d, e_q, e_d, v_q, v_d, b_q, b_d;
  num_t acc_q, acc_d, mx_q, mx_d, my_q, my_d;
  logic [BitCntW-1:0] cnt_q, cnt_d;   // bit position of multiplier / remainder
  logic [BitCntW-1:0] s_q, s_d, j_q, j_d;
  logic [BaseIdxW-1:0] bi_q, bi_d;
  mulop_e op_q, op_d;
  logic [3:0] r15_q, r15_d;            // running n mod 15
  logic [31:0] rb_q, rb_d;             // base mod n (bases < 2^31)
  logic res_q, res_d, ovld_q, ovld_d;

  // shared modular double-and-add step
  logic [63:0] dbl, dbl_r, addx;
  num_t step1, step2;
  logic ybit;
  // small-factor screen: 16^k = 1 mod 15, so n mod 15 is the nibble sum mod 15
  logic [63:0] n_ext;
  logic [15:0] grp;
  logic [6:0] gsum;
  logic [4:0] gfold;
  logic [3:0] r15_nx;
  logic [2:0] r3sum;
  logic div3, div5;
  // serial base remainder step
  logic [32:0] rbx;
  num_t base_full;
  logic [63:0] rb_ext;

  assign ybit  = my_q[cnt_q];
  assign dbl   = {acc_q, 1'b0};
  assign dbl_r = (dbl >= {1'b0, n_q}) ? dbl - {1'b0, n_q} : dbl;
  assign step1 = dbl_r[62:0];
  assign addx  = {1'b0, step1} + {1'b0, mx_q};
  assign step2 = ybit ? ((addx >= {1'b0, n_q}) ? num_t'(addx - {1'b0, n_q}) : addx[62:0])
                      : step1;

  assign n_ext  = {1'b0, n_q};
  assign grp    = n_ext[{cnt_q[1:0], 4'b0000} +: 16];
  assign gsum   = 7'(r15_q) + 7'(grp[15:12]) + 7'(grp[11:8]) + 7'(grp[7:4])
                + 7'(grp[3:0]);
  assign gfold  = 5'(gsum[6:4]) + 5'(gsum[3:0]);
  assign r15_nx = (gfold >= 5'd15) ? 4'(gfold - 5'd15) : gfold[3:0];
  // 4 = 1 mod 3 and 4 = -1 mod 5 on the residue below 15
  assign r3sum  = 3'(r15_nx[3:2]) + 3'(r15_nx[1:0]);
  assign div3   = (r3sum == 3'd0) || (r3sum == 3'd3) || (r3sum == 3'd6);
  assign div5   = (r15_nx[3:2] == r15_nx[1:0]);

  assign base_full = witness_base(bi_q);
  assign rbx = {rb_q, base_full[cnt_q]};
  assign rb_ext = {32'd0, rb_q};

  assign number_ready_o   = (state_q == StIdle) && !ovld_q;
  assign is_prime_o       = res_q;
  assign is_prime_valid_o = ovld_q;

  always_comb begin
    state_d = state_q; n_d = n_q; d_d = d_q; e_d = e_q; v_d = v_q; b_d = b_q;
    acc_d = acc_q; mx_d = mx_q; my_d = my_q; cnt_d = cnt_q; s_d = s_q; j_d = j_q;
    bi_d = bi_q; op_d = op_q; r15_d = r15_q; rb_d = rb_q;
    res_d = res_q; ovld_d = ovld_q;
    if (ovld_q && is_prime_ready_i) ovld_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (number_valid_i && number_ready_o) begin
          n_d = number_i; r15_d = '0;
          cnt_d = BitCntW'(3);
          state_d = StMod3;
        end
      end
      StMod3: begin
        // fold one 16-bit group a cycle, top group first
        r15_d = r15_nx;
        if (cnt_q == '0) begin
          if (n_q == num_t'(2) || n_q == num_t'(3) || n_q == num_t'(5)) begin
            res_d = 1'b1; state_d = StDone;
          end else if (n_q < num_t'(2) || !n_q[0] || div3 || div5) begin
            res_d = 1'b0; state_d = StDone;
          end else begin
            bi_d = '0; rb_d = '0; cnt_d = BitCntW'(NumW - 1); state_d = StBaseRed;
          end
        end else begin
          cnt_d = cnt_q - BitCntW'(1);
        end
      end
      StBaseRed: begin
        // base mod n; the remainder stays below 2^31 since the base does
        if ({31'd0, rbx} >= {1'b0, n_q}) rb_d = 32'(rbx - 33'(n_q));
        else rb_d = rbx[31:0];
        if (cnt_q == '0) state_d = StBaseChk;
        else cnt_d = cnt_q - BitCntW'(1);
      end
      StBaseChk: begin
        if (rb_q == '0) begin
          if (bi_q == BaseIdxW'(NBases - 1)) begin
            res_d = 1'b1; state_d = StDone;
          end else begin
            bi_d = bi_q + BaseIdxW'(1); rb_d = '0; cnt_d = BitCntW'(NumW - 1);
            state_d = StBaseRed;
          end
        end else begin
          d_d = n_q - num_t'(1); s_d = '0;
          b_d = rb_ext[62:0]; v_d = num_t'(1);
          state_d = StSplit;
        end
      end
      StSplit: begin
        if (!d_q[0]) begin
          d_d = d_q >> 1; s_d = s_q + BitCntW'(1);
        end else begin
          e_d = d_q; state_d = StMulStart;
          op_d = d_q[0] ? OpVB : OpBB;
        end
      end
      StMulStart: begin
        // pick operands for the next exponent step
        acc_d = '0; cnt_d = BitCntW'(NumW - 1);
        if (op_q == OpVV) begin
          mx_d = v_q; my_d = v_q;
        end else if (op_q == OpVB) begin
          mx_d = v_q; my_d = b_q;
        end else begin
          mx_d = b_q; my_d = b_q;
        end
        state_d = StMulRun;
      end
      StMulRun: begin
        acc_d = step2;
        if (cnt_q == '0) state_d = StMulDone;
        else cnt_d = cnt_q - BitCntW'(1);
      end
      StMulDone: begin
        state_d = StMulStart;
        unique case (op_q)
          OpVB: begin
            v_d = acc_q; op_d = OpBB;
          end
          OpBB: begin
            b_d = acc_q; e_d = e_q >> 1;
            if ((e_q >> 1) == '0) state_d = StVerdictA;
            else op_d = e_q[1] ? OpVB : OpBB;
          end
          OpVV: begin
            v_d = acc_q; j_d = j_q + BitCntW'(1); state_d = StSquareChk;
          end
          default: state_d = StIdle;
        endcase
      end
      StVerdictA: begin
        j_d = BitCntW'(1);
        if (v_q == num_t'(1) || v_q == n_q - num_t'(1)) state_d = StSquareChk;
        else if (s_q > BitCntW'(1)) begin
          op_d = OpVV; state_d = StMulStart;
        end else begin
          res_d = 1'b0; state_d = StDone;
        end
        if (v_q == num_t'(1) || v_q == n_q - num_t'(1)) j_d = '1; // mark pass
      end
      StSquareChk: begin
        // j all ones flags a pass from the first verdict
        if (j_q == '1 || v_q == n_q - num_t'(1)) begin
          if (bi_q == BaseIdxW'(NBases - 1)) begin
            res_d = 1'b1; state_d = StDone;
          end else begin
            bi_d = bi_q + BaseIdxW'(1); rb_d = '0; cnt_d = BitCntW'(NumW - 1);
            state_d = StBaseRed;
          end
        end else if (v_q == num_t'(1) || j_q >= s_q) begin
          res_d = 1'b0; state_d = StDone;
        end else begin
          op_d = OpVV; state_d = StMulStart;
        end
      end
      StDone: begin
        ovld_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; d_q <= d_d; e_q <= e_d; v_q <= v_d; b_q <= b_d;
    acc_q <= acc_d; mx_q <= mx_d; my_q <= my_d; cnt_q <= cnt_d;
    s_q <= s_d; j_q <= j_d; bi_q <= bi_d; op_q <= op_d;
    r15_q <= r15_d; rb_q <= rb_d; res_q <= res_d;
  end

  // accumulator never reaches the modulus during a product
  a_acc_lt_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMulRun |-> acc_q < n_q) else $error("acc out of range");
  // a result appears only from the finishing state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(is_prime_valid_o) |-> $past(state_q) == StDone) else $error("stray result");
  // no new request while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_prime_valid_o |-> !number_ready_o) else $error("overlap");

endmodule

// ===== dv/tb_primality_test_64bit_core.sv =====
// Testbench for primality_test_64bit_core: directed table, then random numbers,
// each verdict checked against a typed-in value or an in-bench Miller-Rabin predictor.
// Depends on ptest_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_primality_test_64bit_core;
  import ptest_pkg::*;

  localparam int unsigned IdleLimit = 400000;  // cycles with no handshake
  localparam int unsigned NumRandom = 100;
  localparam int unsigned QuietTail = 20;      // last randoms run without gaps

  typedef struct {
    num_t number;
    bit   known;   // verdict typed in below, else from predictor
    bit   verdict;
  } row_t;

  logic clk;
  logic rst_n;
  num_t number;
  logic number_valid;
  logic number_ready;
  logic is_prime;
  logic is_prime_valid;
  logic is_prime_ready;

  bit          verdict_q[$];
  int unsigned n_mismatch;
  int unsigned idle_cycles;
  bit          quiet;

  primality_test_64bit_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .number_i        (number),
    .number_valid_i  (number_valid),
    .number_ready_o  (number_ready),
    .is_prime_o      (is_prime),
    .is_prime_valid_o(is_prime_valid),
    .is_prime_ready_i(is_prime_ready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // (x * y) mod m through a full-width product
  function automatic longint unsigned mulmod(longint unsigned x, longint unsigned y,
                                             longint unsigned m);
    logic [127:0] p;
    p = 128'(x) * 128'(y);
    return 64'(p % 128'(m));
  endfunction

  // strong probable prime check of odd n for base a, 0 < a < n
  function automatic bit sprp(longint unsigned a, longint unsigned n);
    longint unsigned d, v, b;
    int unsigned s;
    d = n - 1;
    s = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      s++;
    end
    v = 1;
    b = a;
    while (d != 0) begin
      if (d[0]) v = mulmod(v, b, n);
      b = mulmod(b, b, n);
      d = d >> 1;
    end
    if (v == 1 || v == n - 1) return 1'b1;
    for (int j = 1; j < s; j++) begin
      v = mulmod(v, v, n);
      if (v == n - 1) return 1'b1;
      if (v == 1) return 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic bit prime_verdict(num_t num);
    longint unsigned n, a;
    longint unsigned bases[7];
    bases = '{2, 325, 9375, 28178, 450775, 9780504, 1795265022};
    n = 64'(num);
    if (n == 2 || n == 3 || n == 5) return 1'b1;
    if (n < 2) return 1'b0;
    if (n % 2 == 0 || n % 3 == 0 || n % 5 == 0) return 1'b0;
    foreach (bases[i]) begin
      a = bases[i] % n;
      if (a != 0 && !sprp(a, n)) return 1'b0;
    end
    return 1'b1;
  endfunction

  // one request, with an optional idle burst ahead of it
  task automatic send_number(num_t num, bit verdict);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap != 0) begin
      number_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    number       <= num;
    number_valid <= 1'b1;
    do @(posedge clk); while (!number_ready);
    verdict_q.push_back(verdict);
    @(negedge clk);
    number_valid <= 1'b0;
  endtask

  // random odd-heavy candidate, mostly short so big primes stay rare
  function automatic num_t random_number();
    num_t v;
    int unsigned pick, nbits;
    pick = $urandom_range(0, 99);
    nbits = (pick < 70) ? $urandom_range(2, 20) : (pick < 94) ? $urandom_range(21, 40) : 63;
    v = num_t'({$urandom, $urandom});
    v = v & ((num_t'(1) << nbits) - 1'b1);
    if (nbits == 63) v = ~v & ((num_t'(1) << 63) - 1'b1);  // spread high bits both ways
    if ($urandom_range(0, 9) != 0) begin
      v[0] = 1'b1;
      // mostly skip the cheap divisibility exits
      while (v % 3 == 0 || v % 5 == 0) v = v + 2;
    end
    return v;
  endfunction

  // output side stall bursts
  initial begin
    is_prime_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        is_prime_ready <= 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        is_prime_ready <= 1'b1;
      end
    end
  end

  // verdict check and idle watchdog
  always @(posedge clk) begin
    if ((number_valid && number_ready) || (is_prime_valid && is_prime_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (is_prime_valid && is_prime_ready) begin
      if (verdict_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected verdict %0b", is_prime);
      end else begin
        if (is_prime !== verdict_q[0]) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("is_prime mismatch: expected %0b got %0b", verdict_q[0], is_prime);
        end
        void'(verdict_q.pop_front());
      end
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    num_t num;
    n_mismatch   = 0;
    idle_cycles  = 0;
    quiet        = 1'b0;
    rst_n        = 1'b0;
    number       = '0;
    number_valid = 1'b0;
    // extremes and trivial cases typed in; the rest predicted
    rows = '{
      '{63'd0, 1, 0}, '{63'd1, 1, 0}, '{63'd2, 1, 1}, '{63'd3, 1, 1},
      '{63'd4, 1, 0}, '{63'd5, 1, 1}, '{63'd6, 1, 0}, '{63'd25, 1, 0},
      '{63'd7, 1, 1}, '{63'd49, 1, 0},
      '{63'd13, 0, 0},                       // divides a witness: base skipped
      '{63'd73, 0, 0},
      '{63'd2047, 0, 0},                     // base-2 strong pseudoprime
      '{63'd561, 0, 0},                      // Carmichael
      '{63'd3215031751, 0, 0},
      '{63'd1000000007, 0, 0},
      '{63'd1000000016000000063, 0, 0},      // product of two large primes
      '{63'h7FFF_FFFF_FFFF_FFFF, 1, 0},      // 2^63-1 is composite
      '{63'd9223372036854775783, 1, 1},      // largest 63-bit prime
      '{63'h4000_0000_0000_0000, 1, 0}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) begin
      send_number(rows[i].number,
                  rows[i].known ? rows[i].verdict : prime_verdict(rows[i].number));
    end

    for (int k = 0; k < NumRandom; k++) begin
      if (k == NumRandom / 2) wait (verdict_q.size() == 0);  // drain once mid-run
      if (k == NumRandom - QuietTail) quiet = 1'b1;
      num = random_number();
      send_number(num, prime_verdict(num));
    end

    wait (verdict_q.size() == 0);
    repeat (200) @(posedge clk);
    if (n_mismatch == 0 && verdict_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
